@@ rtl/grsh_pkg.sv @@
// Shared types, codes and text constants for the game-record score histogram.
// No dependencies; included by the top level by wildcard import.
package grsh_pkg;

    localparam int unsigned DEF_MAX_CAP    = 2047;
    localparam int unsigned DEF_COUNT_BITS = 32;
    localparam int unsigned CAP_BITS       = 11;

    // Item kinds
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_EOT  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Tag identities
    localparam logic [1:0] TAG_NONE   = 2'd0;
    localparam logic [1:0] TAG_EVENT  = 2'd1;
    localparam logic [1:0] TAG_RESULT = 2'd2;
    localparam logic [1:0] TAG_FEN    = 2'd3;

    typedef enum logic [2:0] {
        LP_START, LP_PREFIX, LP_BODY, LP_MOVE, LP_IGNORE
    } line_phase_t;

    typedef enum logic [2:0] {
        CM_OUT, CM_SIGN, CM_FIRST, CM_WHOLE, CM_FRAC, CM_SKIP
    } comment_phase_t;

    typedef enum logic [1:0] {
        OUT_UNKNOWN, OUT_LOSS, OUT_DRAW, OUT_WIN
    } outcome_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         text_byte;
        logic signed [11:0] read_score;
    } in_item_t;

    typedef struct packed {
        logic [31:0] games_in_bin;
        logic [31:0] wins_in_bin;
        logic [31:0] draws_in_bin;
    } out_item_t;

    // Tag prefix text: "[Event ", "[Result ", "[FEN "
    function automatic logic [3:0] tag_length(input logic [1:0] which);
        logic [3:0] len;
        case (which)
            TAG_RESULT: len = 4'd8;
            TAG_FEN:    len = 4'd5;
            default:    len = 4'd7;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tag_byte(input logic [1:0] which, input logic [3:0] pos);
        logic [63:0] txt;
        case (which)
            TAG_RESULT: txt = 64'h5B_52_65_73_75_6C_74_20;
            TAG_FEN:    txt = 64'h5B_46_45_4E_20_00_00_00;
            default:    txt = 64'h5B_45_76_65_6E_74_20_00;
        endcase
        return txt[63 - 8 * pos[2:0] -: 8];
    endfunction

    // Result values: "1-0", "0-1", "1/2-1/2"
    function automatic logic [2:0] res_length(input logic [1:0] c);
        return (c == 2'd2) ? 3'd7 : 3'd3;
    endfunction

    function automatic logic [7:0] res_byte(input logic [1:0] c, input logic [2:0] pos);
        logic [55:0] txt;
        case (c)
            2'd0:    txt = 56'h31_2D_30_00_00_00_00;
            2'd1:    txt = 56'h30_2D_31_00_00_00_00;
            default: txt = 56'h31_2F_32_2D_31_2F_32;
        endcase
        return txt[55 - 8 * pos -: 8];
    endfunction

    function automatic outcome_t res_code(input logic [1:0] c);
        outcome_t o;
        case (c)
            2'd0:    o = OUT_WIN;
            2'd1:    o = OUT_LOSS;
            default: o = OUT_DRAW;
        endcase
        return o;
    endfunction

endpackage

@@ rtl/game_record_score_histogram_top.sv @@
// Top level of the game-record score histogram: text parser, bin memory
// read-modify-write pipeline and result queue. Depends on grsh_pkg.
//
//  channel | ports                      | direction | moves
//  --------+----------------------------+-----------+---------------------------
//  input   | s_valid s_ready s_data     | in        | one text byte / eot / read
//  result  | m_valid m_ready m_data     | out       | one bin read result
//  config  | cfg_we cfg_data            | in        | score_cap
//
// One item per cycle while s_ready is high. Each item walks three stages: parse,
// bin address and memory read, then modify and write back with forwarding of the
// last write. After reset a clearing pass writes the 2*MAX_CAP+1 bins, one per
// cycle (4095 bins at the default), with s_ready low. A four-entry result queue
// holds reads; s_ready also drops when reads in flight would overfill it.
module game_record_score_histogram_top
    import grsh_pkg::*;
#(
    parameter int unsigned MAX_CAP    = DEF_MAX_CAP,
    parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_data
);

    localparam int unsigned NBINS  = 2 * MAX_CAP + 1;
    localparam int unsigned IDX_W  = $clog2(NBINS);
    localparam int unsigned MCAP_W = $clog2(MAX_CAP + 1);
    localparam int unsigned MAG_W  = 24;
    localparam int unsigned ENT_W  = 3 * COUNT_BITS;
    localparam int unsigned QDEPTH = 4;

    localparam logic [MAG_W-1:0] MAX_CAP_M = MAG_W'(MAX_CAP);
    localparam logic [IDX_W-1:0] MAX_CAP_I = IDX_W'(MAX_CAP);
    localparam logic [IDX_W-1:0] LAST_BIN  = IDX_W'(NBINS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

    // ------------------------------------------------------------------
    // Configuration and clearing pass
    // ------------------------------------------------------------------
    logic [CAP_BITS-1:0] cap_reg;
    logic                clearing_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [MAG_W-1:0]    eff_cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_BITS'(2047);
        end else if (cfg_we) begin
            cap_reg <= cfg_data;
        end
    end

    // take the smaller of the register and the build-time cap
    always_comb begin
        if (MAG_W'(cap_reg) > MAX_CAP_M) begin
            eff_cap = MAX_CAP_M;
        end else begin
            eff_cap = MAG_W'(cap_reg);
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    line_phase_t    lp_reg, lp_next;
    comment_phase_t cp_reg, cp_next;
    outcome_t       go_reg, go_next;
    logic [3:0]     tp_reg, tp_next;
    logic [1:0]     tw_reg, tw_next;
    logic [2:0]     vmask_reg, vmask_next;
    logic [2:0]     vcnt_reg, vcnt_next;
    logic           wm_reg, wm_next;
    logic           sn_reg, sn_next;
    logic [15:0]    wh_reg, wh_next;
    logic [6:0]     fr_reg, fr_next;
    logic [1:0]     fd_reg, fd_next;

    logic           s_fire;
    logic           ev_fin;
    logic [6:0]     ev_frac;

    assign s_fire = s_valid && s_ready;

    // Parse one item: next state plus a score event
    always_comb begin
        logic [7:0]   ch;
        logic         digit;
        logic [3:0]   d;
        logic         do_eol;
        line_phase_t  lp_eff;
        logic [19:0]  wacc;
        logic [2:0]   keep;
        logic         decided;
        outcome_t     dec_code;
        logic [1:0]   tsel;

        lp_next    = lp_reg;
        cp_next    = cp_reg;
        go_next    = go_reg;
        tp_next    = tp_reg;
        tw_next    = tw_reg;
        vmask_next = vmask_reg;
        vcnt_next  = vcnt_reg;
        wm_next    = wm_reg;
        sn_next    = sn_reg;
        wh_next    = wh_reg;
        fr_next    = fr_reg;
        fd_next    = fd_reg;
        ev_fin     = 1'b0;

        ch       = s_data.text_byte;
        digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d        = 4'(ch - CH_ZERO);
        do_eol   = (s_data.kind == KIND_EOT) || (s_data.kind == KIND_TEXT && ch == CH_LF);
        lp_eff   = lp_reg;
        wacc     = 20'(wh_reg) * 20'd10 + 20'(d);
        keep     = 3'b000;
        decided  = 1'b0;
        dec_code = OUT_UNKNOWN;
        tsel     = (tw_reg == TAG_NONE) ? TAG_EVENT : tw_reg;

        if (do_eol) begin
            // finish any pending comment, then restart the line
            if (lp_reg == LP_MOVE) begin
                if (cp_reg == CM_SIGN || cp_reg == CM_FIRST) begin
                    wm_next = !wm_reg;
                end else if (cp_reg == CM_WHOLE || cp_reg == CM_FRAC) begin
                    ev_fin  = 1'b1;
                    wm_next = !wm_reg;
                end
            end
            lp_next    = LP_START;
            tp_next    = 4'd0;
            tw_next    = TAG_NONE;
            vmask_next = 3'b000;
            vcnt_next  = 3'd0;
            cp_next    = CM_OUT;
        end else if (s_data.kind == KIND_TEXT) begin
            if (lp_reg == LP_START) begin
                if (ch == CH_LBRACK) begin
                    lp_eff  = LP_IGNORE;
                    lp_next = LP_PREFIX;
                    tp_next = 4'd1;
                    tw_next = TAG_NONE;
                end else begin
                    lp_eff  = (go_reg == OUT_UNKNOWN) ? LP_IGNORE : LP_MOVE;
                    lp_next = lp_eff;
                end
            end

            if (lp_eff == LP_MOVE) begin
                // move text: comments and their leading score
                case (cp_reg)
                    CM_OUT: begin
                        if (ch == CH_LBRACE) begin
                            cp_next = CM_SIGN;
                            sn_next = 1'b0;
                            wh_next = 16'd0;
                            fr_next = 7'd0;
                            fd_next = 2'd0;
                        end
                    end
                    CM_SIGN, CM_FIRST: begin
                        if (cp_reg == CM_SIGN && ch == CH_PLUS) begin
                            cp_next = CM_FIRST;
                        end else if (cp_reg == CM_SIGN && ch == CH_MINUS) begin
                            sn_next = 1'b1;
                            cp_next = CM_FIRST;
                        end else if (digit) begin
                            wh_next = 16'(d);
                            cp_next = CM_WHOLE;
                        end else begin
                            wm_next = !wm_reg;
                            cp_next = (ch == CH_RBRACE) ? CM_OUT : CM_SKIP;
                        end
                    end
                    CM_WHOLE: begin
                        if (digit) begin
                            wh_next = (wacc > 20'd65535) ? 16'hFFFF : wacc[15:0];
                        end else if (ch == CH_DOT) begin
                            cp_next = CM_FRAC;
                        end else begin
                            ev_fin  = 1'b1;
                            wm_next = !wm_reg;
                            cp_next = (ch == CH_RBRACE) ? CM_OUT : CM_SKIP;
                        end
                    end
                    CM_FRAC: begin
                        if (digit) begin
                            fr_next = 7'(fr_reg * 7'd10 + 7'(d));
                            fd_next = fd_reg + 2'd1;
                            if (fd_reg != 2'd0) begin
                                ev_fin  = 1'b1;
                                wm_next = !wm_reg;
                                cp_next = CM_SKIP;
                            end
                        end else begin
                            ev_fin  = 1'b1;
                            wm_next = !wm_reg;
                            cp_next = (ch == CH_RBRACE) ? CM_OUT : CM_SKIP;
                        end
                    end
                    default: begin
                        cp_next = (ch == CH_RBRACE) ? CM_OUT : CM_SKIP;
                    end
                endcase
            end else if (lp_eff == LP_PREFIX) begin
                // match the tag name
                if (tp_reg == 4'd1) begin
                    if (ch == CH_E) begin
                        tsel = TAG_EVENT;
                    end else if (ch == CH_R) begin
                        tsel = TAG_RESULT;
                    end else if (ch == CH_F) begin
                        tsel = TAG_FEN;
                    end else begin
                        tsel = TAG_NONE;
                    end
                    tw_next = tsel;
                end
                if (tp_reg == 4'd1 && tsel == TAG_NONE) begin
                    lp_next = LP_IGNORE;
                end else if (tp_reg >= tag_length(tsel) || tag_byte(tsel, tp_reg) != ch) begin
                    lp_next = LP_IGNORE;
                end else if (tp_reg + 4'd1 == tag_length(tsel)) begin
                    tp_next = 4'd0;
                    if (tsel == TAG_EVENT) begin
                        go_next = OUT_UNKNOWN;
                        wm_next = 1'b1;
                        lp_next = LP_IGNORE;
                    end else if (tsel == TAG_RESULT) begin
                        lp_next = LP_BODY;
                    end else begin
                        wm_next = 1'b1;
                        lp_next = LP_BODY;
                    end
                end else begin
                    tp_next = tp_reg + 4'd1;
                end
            end else if (lp_eff == LP_BODY) begin
                if (tw_reg == TAG_RESULT) begin
                    // match the quoted result value
                    if (tp_reg == 4'd0) begin
                        if (ch == CH_QUOTE) begin
                            go_next    = OUT_UNKNOWN;
                            vmask_next = 3'b111;
                            vcnt_next  = 3'd0;
                            tp_next    = 4'd1;
                        end
                    end else begin
                        for (int c = 0; c < 3; c++) begin
                            if (vmask_reg[c] && vcnt_reg < res_length(2'(c))
                                && res_byte(2'(c), vcnt_reg) == ch) begin
                                keep[c] = 1'b1;
                                if (vcnt_reg + 3'd1 == res_length(2'(c))) begin
                                    decided  = 1'b1;
                                    dec_code = res_code(2'(c));
                                end
                            end
                        end
                        if (decided) begin
                            go_next = dec_code;
                            lp_next = LP_IGNORE;
                        end else if (keep == 3'b000) begin
                            lp_next = LP_IGNORE;
                        end else begin
                            vmask_next = keep;
                            vcnt_next  = vcnt_reg + 3'd1;
                        end
                    end
                end else begin
                    // side to move after the first space in the FEN value
                    if (tp_reg == 4'd0) begin
                        if (ch == CH_QUOTE) begin
                            tp_next = 4'd1;
                        end
                    end else if (tp_reg == 4'd1) begin
                        if (ch == CH_SPACE) begin
                            tp_next = 4'd2;
                        end
                    end else begin
                        if (ch == CH_B) begin
                            wm_next = 1'b0;
                        end
                        lp_next = LP_IGNORE;
                    end
                end
            end
        end

        // fraction in centipawns as it stands after this byte
        case (fd_next)
            2'd0:    ev_frac = 7'd0;
            2'd1:    ev_frac = 7'(fr_next * 7'd10);
            default: ev_frac = fr_next;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg    <= LP_START;
            cp_reg    <= CM_OUT;
            go_reg    <= OUT_UNKNOWN;
            tp_reg    <= 4'd0;
            tw_reg    <= TAG_NONE;
            vmask_reg <= 3'b000;
            vcnt_reg  <= 3'd0;
            wm_reg    <= 1'b1;
            sn_reg    <= 1'b0;
            wh_reg    <= 16'd0;
            fr_reg    <= 7'd0;
            fd_reg    <= 2'd0;
        end else if (s_fire) begin
            lp_reg    <= lp_next;
            cp_reg    <= cp_next;
            go_reg    <= go_next;
            tp_reg    <= tp_next;
            tw_reg    <= tw_next;
            vmask_reg <= vmask_next;
            vcnt_reg  <= vcnt_next;
            wm_reg    <= wm_next;
            sn_reg    <= sn_next;
            wh_reg    <= wh_next;
            fr_reg    <= fr_next;
            fd_reg    <= fd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: score or read request
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic             s1_read_reg;
    logic             s1_neg_reg;
    logic             s1_win_reg;
    logic             s1_draw_reg;
    logic [15:0]      s1_whole_reg;
    logic [6:0]       s1_frac_reg;
    logic [11:0]      s1_rmag_reg;
    logic             s1_is_read;
    logic [11:0]      rmag;

    assign s1_is_read = s_data.kind == KIND_READ;
    assign rmag = s_data.read_score[11] ? 12'(-s_data.read_score) : s_data.read_score;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_fire && (s1_is_read || ev_fin);
        end
    end

    always_ff @(posedge aclk) begin
        s1_read_reg  <= s1_is_read;
        s1_neg_reg   <= s1_is_read ? s_data.read_score[11] : (sn_reg != !wm_reg);
        s1_win_reg   <= go_reg == OUT_WIN;
        s1_draw_reg  <= go_reg == OUT_DRAW;
        s1_whole_reg <= wh_reg;
        s1_frac_reg  <= ev_frac;
        s1_rmag_reg  <= rmag;
    end

    // centipawn magnitude, cap check and bin index
    logic [MAG_W-1:0] s1_mag;
    logic             s1_in_cap;
    logic [IDX_W-1:0] s1_idx;

    always_comb begin
        if (s1_read_reg) begin
            s1_mag = MAG_W'(s1_rmag_reg);
        end else begin
            s1_mag = MAG_W'(s1_whole_reg) * MAG_W'(100) + MAG_W'(s1_frac_reg);
        end
        s1_in_cap = s1_mag <= eff_cap;
        if (s1_neg_reg) begin
            s1_idx = MAX_CAP_I - IDX_W'(s1_mag[MCAP_W-1:0]);
        end else begin
            s1_idx = MAX_CAP_I + IDX_W'(s1_mag[MCAP_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: bin memory read-modify-write
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] bin_mem [NBINS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             s2_valid_reg;
    logic             s2_read_reg;
    logic             s2_in_cap_reg;
    logic             s2_win_reg;
    logic             s2_draw_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic             wr_valid_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    logic [ENT_W-1:0] wr_data_reg;
    logic [ENT_W-1:0] cur_entry;
    logic [ENT_W-1:0] new_entry;
    logic             s2_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_read_reg   <= s1_read_reg;
        s2_in_cap_reg <= s1_in_cap;
        s2_win_reg    <= s1_win_reg;
        s2_draw_reg   <= s1_draw_reg;
        s2_idx_reg    <= s1_idx;
    end

    // forward the write that lands on the edge of this entry's read
    assign cur_entry = (wr_valid_reg && wr_idx_reg == s2_idx_reg) ? wr_data_reg : rd_data_reg;
    assign s2_write  = s2_valid_reg && !s2_read_reg && s2_in_cap_reg;

    // saturating increments of games, wins and draws
    always_comb begin
        logic [COUNT_BITS-1:0] g;
        logic [COUNT_BITS-1:0] w;
        logic [COUNT_BITS-1:0] dr;
        g  = cur_entry[ENT_W-1 -: COUNT_BITS];
        w  = cur_entry[2*COUNT_BITS-1 -: COUNT_BITS];
        dr = cur_entry[COUNT_BITS-1:0];
        if (g != CNT_TOP) begin
            g = g + 1'b1;
        end
        if (s2_win_reg && w != CNT_TOP) begin
            w = w + 1'b1;
        end
        if (s2_draw_reg && dr != CNT_TOP) begin
            dr = dr + 1'b1;
        end
        new_entry = {g, w, dr};
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= bin_mem[s1_idx];
        if (clearing_reg) begin
            bin_mem[clr_addr_reg] <= '0;
        end else if (s2_write) begin
            bin_mem[s2_idx_reg] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= s2_write;
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg  <= s2_idx_reg;
        wr_data_reg <= new_entry;
    end

    // sweep every bin to zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == LAST_BIN) begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    out_item_t  q_mem [QDEPTH];
    logic [1:0] q_wr_reg;
    logic [1:0] q_rd_reg;
    logic [2:0] q_cnt_reg;
    logic       q_push;
    logic       q_pop;
    out_item_t  q_item;
    logic [2:0] in_flight;

    assign q_push = s2_valid_reg && s2_read_reg;
    assign q_pop  = m_valid && m_ready;

    // clip counts to 32 bits; outside the cap reads as zero
    always_comb begin
        if (s2_in_cap_reg) begin
            q_item.games_in_bin = 32'(cur_entry[ENT_W-1 -: COUNT_BITS]);
            q_item.wins_in_bin  = 32'(cur_entry[2*COUNT_BITS-1 -: COUNT_BITS]);
            q_item.draws_in_bin = 32'(cur_entry[COUNT_BITS-1:0]);
        end else begin
            q_item = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            q_mem[q_wr_reg] <= q_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= 2'd0;
            q_rd_reg  <= 2'd0;
            q_cnt_reg <= 3'd0;
        end else begin
            if (q_push) begin
                q_wr_reg <= q_wr_reg + 2'd1;
            end
            if (q_pop) begin
                q_rd_reg <= q_rd_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + 3'(q_push) - 3'(q_pop);
        end
    end

    assign m_valid = q_cnt_reg != 3'd0;
    assign m_data  = q_mem[q_rd_reg];

    // hold the input while queued and in-flight reads would fill the queue
    assign in_flight = q_cnt_reg + 3'(s1_valid_reg && s1_read_reg)
                     + 3'(s2_valid_reg && s2_read_reg);
    assign s_ready   = !clearing_reg && (in_flight < 3'(QDEPTH));

endmodule
